// ----- rtl/drum_pad_peak_velocity_defines.svh -----
// assertion macros shared by the drum pad velocity block
`ifndef DRUM_PAD_PEAK_VELOCITY_DEFINES_SVH
`define DRUM_PAD_PEAK_VELOCITY_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define DPPV_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("drum pad velocity check failed");

// next-cycle implication, sampled on clk, off during reset
`define DPPV_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("drum pad velocity check failed");

`endif

// ----- rtl/dppv_pkg.sv -----
// package: widths, codes and shared types of the drum pad velocity block
package dppv_pkg;

	localparam int SAMPLE_BITS   = 12;
	localparam int VEL_BITS      = 7;
	localparam int WIN_BITS      = 8;
	localparam int ELAPSED_BITS  = 9;
	localparam int REM_BITS      = SAMPLE_BITS + VEL_BITS;
	localparam int DIV_STEPS     = VEL_BITS;
	localparam int CNT_BITS      = $clog2(DIV_STEPS);
	localparam int IN_DATA_BITS  = ((SAMPLE_BITS + 1 + 7) / 8) * 8;
	localparam int OUT_DATA_BITS = ((VEL_BITS + 2 + 7) / 8) * 8;
	localparam int ADDR_BITS     = 4;
	localparam int APB_DATA_BITS = 32;

	typedef logic [SAMPLE_BITS-1:0]  sample_t;
	typedef logic [VEL_BITS-1:0]     vel_t;
	typedef logic [WIN_BITS-1:0]     win_t;
	typedef logic [ELAPSED_BITS-1:0] elapsed_t;

	localparam vel_t     VEL_MAX     = vel_t'(127);
	localparam vel_t     VEL_MIN     = vel_t'(1);
	localparam int       VEL_SPAN    = 126;
	localparam elapsed_t ELAPSED_MAX = {ELAPSED_BITS{1'b1}};

	localparam sample_t THRESHOLD_RESET = sample_t'(200);
	localparam sample_t UPPER_RESET     = sample_t'(3000);
	localparam win_t    WINDOW_RESET    = win_t'(5);
	localparam sample_t CEILING_RESET   = sample_t'(3750);

	typedef enum logic [1:0] {
		REG_TRIG_LEVEL,
		REG_FULL_LEVEL,
		REG_WINDOW_MS,
		REG_PEAK_CEILING
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_DIV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		sample_t trig_level;
		sample_t full_level;
		win_t    window_ms;
		sample_t peak_ceiling;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic calc;
		logic div_step;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_done;
		logic out_free;
	} dp_status_t;

endpackage

// ----- rtl/dppv_ctrl.sv -----
// controller: sequences load, evaluate, divide when a closing window needs it, and emit for each word
`include "drum_pad_peak_velocity_defines.svh"

module dppv_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  dppv_pkg::dp_status_t status,
	output dppv_pkg::dp_cmd_t    cmd
);
	import dppv_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_CALC;
				end
			end
			ST_CALC: begin
				cmd.calc = 1'b1;
				state_d  = status.need_div ? ST_DIV : ST_EMIT;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
		endcase
	end

	`DPPV_ASSERT_NOW(a_emit_only_when_free, cmd.emit, status.out_free)
	`DPPV_ASSERT_NEXT(a_calc_moves_on, state_q == ST_CALC,
		state_q == ST_DIV || state_q == ST_EMIT)
	`DPPV_ASSERT_NEXT(a_div_finishes, state_q == ST_DIV && status.div_done, state_q == ST_EMIT)

endmodule

// ----- rtl/dppv_dp.sv -----
// datapath: hit and window state, peak tracking, serial divider, output register
`include "drum_pad_peak_velocity_defines.svh"

module dppv_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dppv_pkg::cfg_t                      cfg,
	input  logic [dppv_pkg::IN_DATA_BITS-1:0]   s_tdata,
	input  dppv_pkg::dp_cmd_t                   cmd,
	output dppv_pkg::dp_status_t                status,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [dppv_pkg::OUT_DATA_BITS-1:0]  m_tdata
);
	import dppv_pkg::*;

	localparam int OUT_PAD = OUT_DATA_BITS - VEL_BITS - 2;

	// registered input word
	sample_t sample_q;
	logic    tick_q;

	// pad state
	logic     capturing_q;
	sample_t  peak_q;
	elapsed_t elapsed_q;
	logic     last_hit_q;
	vel_t     held_q;
	logic     closed_q;
	logic     trig_q;

	// divider
	logic [REM_BITS-1:0] rem_q;
	sample_t             divisor_q;
	vel_t                quot_q;
	logic [CNT_BITS-1:0] cnt_q;

	// output register
	logic out_valid_q;
	vel_t out_vel_q;
	logic out_new_q;
	logic out_trig_q;

	logic                hit;
	logic                trig;
	logic                opening;
	logic                cap_now;
	elapsed_t            elapsed_n;
	sample_t             peak_base;
	sample_t             peak_n;
	logic                closing;
	logic                sat_high;
	logic                clamp_low;
	sample_t             span_num;
	logic [REM_BITS-1:0] scaled;
	logic [REM_BITS-1:0] div_shift;
	logic                div_ge;
	vel_t                quot_n;

	always_comb begin
		hit       = sample_q > cfg.trig_level;
		trig      = hit && !last_hit_q;
		opening   = hit && !capturing_q;
		cap_now   = capturing_q || hit;
		peak_base = opening ? '0 : peak_q;
		if (opening) begin
			elapsed_n = '0;
		end else if (capturing_q && tick_q && elapsed_q != ELAPSED_MAX) begin
			elapsed_n = elapsed_q + elapsed_t'(1);
		end else begin
			elapsed_n = elapsed_q;
		end
		if (cap_now && sample_q < cfg.peak_ceiling && sample_q > peak_base) begin
			peak_n = sample_q;
		end else begin
			peak_n = peak_base;
		end
		closing   = capturing_q && !hit && elapsed_n > {1'b0, cfg.window_ms};
		sat_high  = peak_n >= cfg.full_level || cfg.full_level <= cfg.trig_level;
		clamp_low = peak_n < cfg.trig_level;
		span_num  = peak_n - cfg.trig_level;
		// times 126 as a shift pair: x*128 - x*2
		scaled    = (REM_BITS'(span_num) << VEL_BITS) - (REM_BITS'(span_num) << 1);
		div_shift = REM_BITS'(divisor_q) << cnt_q;
		div_ge    = rem_q >= div_shift;
		quot_n    = {quot_q[VEL_BITS-2:0], div_ge};
	end

	assign status.need_div = closing && !sat_high && !clamp_low;
	assign status.div_done = cnt_q == '0;
	assign status.out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q <= s_tdata[SAMPLE_BITS-1:0];
			tick_q   <= s_tdata[SAMPLE_BITS];
		end
		if (cmd.calc) begin
			trig_q    <= trig;
			closed_q  <= closing;
			rem_q     <= scaled;
			divisor_q <= cfg.full_level - cfg.trig_level;
			quot_q    <= '0;
			cnt_q     <= CNT_BITS'(DIV_STEPS - 1);
		end
		if (cmd.div_step) begin
			// quotient stays below 128, so seven restoring steps suffice
			if (div_ge) begin
				rem_q <= rem_q - div_shift;
			end
			quot_q <= quot_n;
			cnt_q  <= cnt_q - CNT_BITS'(1);
		end
		if (cmd.emit) begin
			out_vel_q  <= held_q;
			out_new_q  <= closed_q;
			out_trig_q <= trig_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capturing_q <= 1'b0;
			peak_q      <= '0;
			elapsed_q   <= '0;
			last_hit_q  <= 1'b0;
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.calc) begin
				last_hit_q <= hit;
				elapsed_q  <= elapsed_n;
				if (closing) begin
					capturing_q <= 1'b0;
					peak_q      <= '0;
					if (sat_high) begin
						held_q <= VEL_MAX;
					end else if (clamp_low) begin
						held_q <= VEL_MIN;
					end
				end else begin
					capturing_q <= cap_now;
					peak_q      <= peak_n;
				end
			end
			if (cmd.div_step && status.div_done) begin
				held_q <= quot_n + VEL_MIN;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{OUT_PAD{1'b0}}, out_trig_q, out_new_q, out_vel_q};

	`DPPV_ASSERT_NEXT(a_close_ends_capture, cmd.calc && closing, !capturing_q)
	`DPPV_ASSERT_NEXT(a_div_result_nonzero, cmd.div_step && status.div_done, held_q != '0)
	`DPPV_ASSERT_NEXT(a_emit_sets_valid, cmd.emit, m_tvalid)

endmodule

// ----- rtl/drum_pad_peak_velocity.sv -----
// Piezo drum pad trigger with peak-hold velocity, top level with register port.
//
// Input channel s_*: one word per ADC sample, holding the sample and a flag
// that a millisecond boundary passed since the previous sample.
// Output channel m_*: one word per input word, holding the held velocity,
// a flag that a capture window closed on this sample, and the hit rising edge.
// APB port: threshold, upper limit, window length and peak ceiling at byte
// addresses 0, 4, 8 and 12; write only while no word is in flight.
// Each word is taken in the idle state, evaluated in the calc state, and
// placed in the output register in the emit state once the slot is free.
// When a window closes with a peak inside the mapping range, a 7-step
// restoring divider runs between evaluation and emit. The controller holds
// one word at a time and takes no new word until the last one is placed.
// Reset clears all pad state, the held velocity and the output valid flag,
// and loads the register defaults. A stalled receiver holds the output word;
// one further input word is taken and evaluated, then waits for a free slot.
`include "drum_pad_peak_velocity_defines.svh"

module drum_pad_peak_velocity (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// [11:0] sample, [12] ms_tick, upper bits zero
	input  logic [dppv_pkg::IN_DATA_BITS-1:0]    s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// [6:0] velocity, [7] velocity_new, [8] triggered, upper bits zero
	output logic [dppv_pkg::OUT_DATA_BITS-1:0]   m_tdata,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [dppv_pkg::ADDR_BITS-1:0]       paddr,
	input  logic [dppv_pkg::APB_DATA_BITS-1:0]   pwdata,
	output logic [dppv_pkg::APB_DATA_BITS-1:0]   prdata,
	output logic                                 pready
);
	import dppv_pkg::*;

	cfg_t       cfg_q;
	reg_idx_t   reg_idx;
	logic       cfg_write;
	dp_cmd_t    cmd;
	dp_status_t status;

	assign pready    = 1'b1;
	assign reg_idx   = reg_idx_t'(paddr[3:2]);
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trig_level   <= THRESHOLD_RESET;
			cfg_q.full_level   <= UPPER_RESET;
			cfg_q.window_ms    <= WINDOW_RESET;
			cfg_q.peak_ceiling <= CEILING_RESET;
		end else if (cfg_write) begin
			unique case (reg_idx)
				REG_TRIG_LEVEL:   cfg_q.trig_level   <= pwdata[SAMPLE_BITS-1:0];
				REG_FULL_LEVEL:   cfg_q.full_level   <= pwdata[SAMPLE_BITS-1:0];
				REG_WINDOW_MS:    cfg_q.window_ms    <= pwdata[WIN_BITS-1:0];
				REG_PEAK_CEILING: cfg_q.peak_ceiling <= pwdata[SAMPLE_BITS-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_TRIG_LEVEL:   prdata = APB_DATA_BITS'(cfg_q.trig_level);
			REG_FULL_LEVEL:   prdata = APB_DATA_BITS'(cfg_q.full_level);
			REG_WINDOW_MS:    prdata = APB_DATA_BITS'(cfg_q.window_ms);
			REG_PEAK_CEILING: prdata = APB_DATA_BITS'(cfg_q.peak_ceiling);
		endcase
	end

	dppv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	dppv_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.s_tdata  (s_tdata),
		.cmd      (cmd),
		.status   (status),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ----- tb/sv/tb_drum_pad_peak_velocity.sv -----
// testbench for the drum pad peak velocity block: pad predictor, stream drivers, register writes
module tb_drum_pad_peak_velocity;
	timeunit 1ns;
	timeprecision 1ps;
	import dppv_pkg::*;

	localparam int HOLD_CYCLES  = 200;
	localparam int DRAIN_CYCLES = 20;
	localparam int MAX_REPORTS  = 10;

	typedef struct packed {
		vel_t velocity;
		logic closed;
		logic trig;
	} pad_word_t;

	class velocity_scoreboard;
		sample_t   threshold;
		sample_t   upper;
		win_t      window;
		sample_t   ceiling;
		logic      capturing;
		logic      last_hit;
		sample_t   peak;
		elapsed_t  elapsed;
		vel_t      held;
		pad_word_t pad_words_q[$];
		int        errors;

		function new();
			threshold = THRESHOLD_RESET;
			upper     = UPPER_RESET;
			window    = WINDOW_RESET;
			ceiling   = CEILING_RESET;
			capturing = 1'b0;
			last_hit  = 1'b0;
			peak      = '0;
			elapsed   = '0;
			held      = '0;
			errors    = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [APB_DATA_BITS-1:0] value);
			case (idx)
			REG_TRIG_LEVEL:   threshold = value[SAMPLE_BITS-1:0];
			REG_FULL_LEVEL:   upper     = value[SAMPLE_BITS-1:0];
			REG_WINDOW_MS:    window    = value[WIN_BITS-1:0];
			REG_PEAK_CEILING: ceiling   = value[SAMPLE_BITS-1:0];
			endcase
		endfunction

		function int pending();
			return pad_words_q.size();
		endfunction

		// linear map threshold..upper onto 1..126, full scale at or above upper or if upper <= threshold
		function vel_t scale_peak(sample_t pk);
			int span;
			int offset;
			if (pk >= upper || upper <= threshold)
				return VEL_MAX;
			if (pk < threshold)
				return VEL_MIN;
			span   = int'(upper) - int'(threshold);
			offset = int'(pk) - int'(threshold);
			return vel_t'(offset * VEL_SPAN / span + int'(VEL_MIN));
		endfunction

		function void note_sample(sample_t s, logic tick);
			logic      hit;
			pad_word_t w;
			hit     = s > threshold;
			w.trig  = hit && !last_hit;
			w.closed = 1'b0;
			// the opening sample does not count its tick
			if (hit && !capturing) begin
				capturing = 1'b1;
				elapsed   = '0;
				peak      = '0;
			end else if (capturing && tick && elapsed != ELAPSED_MAX) begin
				elapsed = elapsed + 1'b1;
			end
			if (capturing) begin
				if (s < ceiling && s > peak)
					peak = s;
				if (!hit && elapsed > window) begin
					held      = scale_peak(peak);
					peak      = '0;
					capturing = 1'b0;
					w.closed  = 1'b1;
				end
			end
			last_hit   = hit;
			w.velocity = held;
			pad_words_q.push_back(w);
		endfunction

		function void report(string msg);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: %s", $realtime, msg);
		endfunction

		function void check_word(logic [OUT_DATA_BITS-1:0] word);
			pad_word_t want;
			if (pad_words_q.size() == 0) begin
				report($sformatf("output word %h with nothing expected", word));
				return;
			end
			want = pad_words_q.pop_front();
			if (word[VEL_BITS-1:0] !== want.velocity || word[VEL_BITS] !== want.closed ||
					word[VEL_BITS+1] !== want.trig ||
					word[OUT_DATA_BITS-1:VEL_BITS+2] !== '0)
				report($sformatf({"word mismatch: expected vel %0d new %0b trig %0b, ",
					"got vel %0d new %0b trig %0b (word %h)"},
					want.velocity, want.closed, want.trig,
					word[VEL_BITS-1:0], word[VEL_BITS], word[VEL_BITS+1], word));
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     s_tvalid;
	logic                     s_tready;
	// [11:0] sample, [12] ms_tick, upper bits zero
	logic [IN_DATA_BITS-1:0]  s_tdata;
	logic                     m_tvalid;
	logic                     m_tready;
	// [6:0] velocity, [7] velocity_new, [8] triggered, upper bits zero
	logic [OUT_DATA_BITS-1:0] m_tdata;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [ADDR_BITS-1:0]     paddr;
	logic [APB_DATA_BITS-1:0] pwdata;
	logic [APB_DATA_BITS-1:0] prdata;
	logic                     pready;

	velocity_scoreboard sb = new();
	bit tx_idle;
	bit rx_idle;
	bit hold_req;
	int sample_count;

	drum_pad_peak_velocity dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// sender: one word per sample, valid kept high across back-to-back words
	task automatic send_word(sample_t s, logic tick);
		int gap;
		gap = tx_idle ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_DATA_BITS'({tick, s});
		do @(posedge clk); while (!s_tready);
		sb.note_sample(s, tick);
		sample_count++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic apb_write(reg_idx_t idx, logic [APB_DATA_BITS-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, value);
	endtask

	task automatic configure(int thr, int up, int win, int ceiling_v);
		wait_drained();
		apb_write(REG_TRIG_LEVEL, thr);
		apb_write(REG_FULL_LEVEL, up);
		apb_write(REG_WINDOW_MS, win);
		apb_write(REG_PEAK_CEILING, ceiling_v);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		tx_idle = $urandom_range(0, 3) != 0;
		rx_idle = $urandom_range(0, 3) != 0;
	endtask

	// a hit of a few samples, then decay until the window closes or is cut short
	task automatic strike();
		int hits;
		int cap;
		int k;
		hits = $urandom_range(1, 4);
		repeat (hits)
			send_word(sample_t'($urandom_range(int'(sb.threshold) + 1, 4095)),
				1'($urandom_range(0, 1)));
		cap = ($urandom_range(0, 4) == 0) ? $urandom_range(0, int'(sb.window)) : 64;
		k = 0;
		while (sb.capturing && k < cap) begin
			send_word(sample_t'($urandom_range(0, int'(sb.threshold))),
				$urandom_range(0, 3) != 0);
			k++;
		end
	endtask

	task automatic random_phase(int n);
		int stop;
		stop = sample_count + n;
		while (sample_count < stop) begin
			if ($urandom_range(0, 9) < 7 && sb.threshold != '1)
				strike();
			else
				send_word(sample_t'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)));
		end
	endtask

	// receiver parks for a long stretch while the sender keeps going
	task automatic pressure_burst();
		bit keep;
		keep = tx_idle;
		tx_idle = 1'b0;
		hold_req = 1'b1;
		repeat (30) send_word(sample_t'($urandom), 1'($urandom));
		tx_idle = keep;
	endtask

	initial begin
		int stall;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			stall = rx_idle ? $urandom_range(0, 8) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			sb.check_word(m_tdata);
		end
	end

	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		tx_idle  = 1'b1;
		rx_idle  = 1'b1;
		hold_req = 1'b0;
		sample_count = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: peak below threshold, just above threshold, peak at upper,
		// samples at and above the ceiling
		send_word(12'd0, 1'b0);
		send_word(12'd4095, 1'b0);
		send_word(12'd150, 1'b1);
		repeat (5) send_word(12'd0, 1'b1);
		send_word(12'd201, 1'b1);
		send_word(12'd3750, 1'b1);
		send_word(12'd200, 1'b1);
		repeat (4) send_word(12'd0, 1'b1);
		send_word(12'd3000, 1'b0);
		repeat (6) send_word(12'd0, 1'b1);

		configure(0, 4095, 0, 4095);
		random_phase(50);
		pressure_burst();
		// nothing can be a hit here
		configure(4095, 0, 1, 0);
		random_phase(20);
		// upper below threshold
		configure(1000, 500, 3, 3000);
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		random_phase(40);
		// upper equal to threshold
		configure(300, 300, 2, 2500);
		random_phase(25);
		// ceiling at zero keeps the peak at zero
		configure(500, 2000, 4, 0);
		random_phase(35);
		// long window with the tick count pinned at its maximum
		configure(100, 4000, 255, 3800);
		repeat (520) send_word(sample_t'($urandom_range(101, 4095)), 1'b1);
		send_word(sample_t'($urandom_range(0, 100)), 1'b1);

		repeat (4) begin
			int thr;
			int up;
			int ceiling_v;
			thr = $urandom_range(0, 2500);
			up = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
				: $urandom_range(thr, 4095);
			ceiling_v = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095)
				: $urandom_range(up, 4095);
			configure(thr, up, $urandom_range(0, 8), ceiling_v);
			random_phase(25);
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/dppv_pkg.sv
rtl/dppv_ctrl.sv
rtl/dppv_dp.sv
rtl/drum_pad_peak_velocity.sv
tb/sv/tb_drum_pad_peak_velocity.sv
